// File: sv/ffpa_pkg.sv
// Shared constants, codes and types for the first-fit page range allocator.
package ffpa_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 64;
  localparam int unsigned ADDR_BITS_DEF   = 52;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned COUNT_W = 7;

  localparam int unsigned PAGE_BITS = 12;
  localparam logic [31:0] LIMIT_4G  = 32'hFFFF_FFFF;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOMEM = 1'b1;

  typedef struct packed {
    logic hit;
    logic stop;
  } fit_t;

endpackage

// File: sv/ffpa_table.sv
// Range table: start, end, free arrays; entry write, start-only update, registered read ports.
module ffpa_table #(
  parameter int unsigned TABLE_DEPTH = ffpa_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ADDR_BITS   = ffpa_pkg::ADDR_BITS_DEF,
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 ent_we_i,
  input  logic [AW-1:0]        ent_waddr_i,
  input  logic [ADDR_BITS-1:0] ent_wstart_i,
  input  logic [ADDR_BITS-1:0] ent_wend_i,
  input  logic                 ent_wfree_i,
  input  logic                 upd_we_i,
  input  logic [AW-1:0]        upd_waddr_i,
  input  logic [ADDR_BITS-1:0] upd_wstart_i,
  input  logic                 rd_en_i,
  input  logic [AW-1:0]        rd_addr_i,
  output logic [ADDR_BITS-1:0] rd_start_o,
  output logic [ADDR_BITS-1:0] rd_end_o,
  output logic                 rd_free_o
);

  logic [ADDR_BITS-1:0] start_mem [TABLE_DEPTH];
  logic [ADDR_BITS-1:0] end_mem   [TABLE_DEPTH];
  logic                 free_mem  [TABLE_DEPTH];

  logic                 start_we;
  logic [AW-1:0]        start_waddr;
  logic [ADDR_BITS-1:0] start_wdata;

  always_comb begin
    start_we    = ent_we_i | upd_we_i;
    start_waddr = ent_we_i ? ent_waddr_i  : upd_waddr_i;
    start_wdata = ent_we_i ? ent_wstart_i : upd_wstart_i;
  end

  always_ff @(posedge clk_i) begin
    if (start_we) begin
      start_mem[start_waddr] <= start_wdata;
    end
    if (ent_we_i) begin
      end_mem[ent_waddr_i]  <= ent_wend_i;
      free_mem[ent_waddr_i] <= ent_wfree_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_start_o <= start_mem[rd_addr_i];
      rd_end_o   <= end_mem[rd_addr_i];
      rd_free_o  <= free_mem[rd_addr_i];
    end
  end

endmodule

// File: sv/ffpa_fit.sv
// Fit check of one table entry against a rounded request size.
module ffpa_fit #(
  parameter int unsigned ADDR_BITS = ffpa_pkg::ADDR_BITS_DEF
) (
  input  logic                 free_i,
  input  logic [ADDR_BITS-1:0] lo_i,
  input  logic [ADDR_BITS-1:0] hi_i,
  input  logic [ADDR_BITS-1:0] size_i,
  input  logic                 low_only_i,
  output ffpa_pkg::fit_t       fit_o
);

  logic [ADDR_BITS:0] diff;
  logic               fits;
  logic               lo_above;
  logic               hi_above;
  logic               size_above;
  logic [31:0]        clip_span;
  logic               fits_clip;
  logic               cand;

  always_comb begin
    diff       = {1'b0, hi_i} - {1'b0, lo_i};
    fits       = diff[ADDR_BITS] ? (size_i == '0) : (size_i <= diff[ADDR_BITS-1:0]);
    lo_above   = |lo_i[ADDR_BITS-1:32];
    hi_above   = |hi_i[ADDR_BITS-1:32];
    size_above = |size_i[ADDR_BITS-1:32];
    clip_span  = ffpa_pkg::LIMIT_4G - lo_i[31:0];
    fits_clip  = !size_above && (size_i[31:0] <= clip_span);
    cand       = free_i && fits;
    fit_o.stop = cand && low_only_i && lo_above;
    fit_o.hit  = cand && (!low_only_i || (!lo_above && (!hi_above || fits_clip)));
  end

endmodule

// File: sv/first_fit_page_range_allocator_unit.sv
// Top level: command handling, table scan sequencer and result register.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | cmd, entry_index/start/end/free, size, below_4g
//   out     | output    | out_valid_o/out_ready_i| status, alloc_start
//   cfg     | input     | cfg_we_i              | cfg_wdata_i (entry_count)
//
// A write updates the table at the accepting edge (index < TABLE_DEPTH) and presents OK there.
// An allocate reads one entry per cycle and checks it in the cycle after the read: the scan ends
// at the first entry that fits or stops the search, or fails once min(entry_count, TABLE_DEPTH)
// entries are checked; a rounding overflow or an entry_count of 0 answers at once.
// Reset clears the control state and entry_count; table contents stay unknown until written.
// A finished result that finds the output occupied is held and stalls the input until drained.
module first_fit_page_range_allocator_unit #(
  parameter int unsigned TABLE_DEPTH = ffpa_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned ADDR_BITS   = ffpa_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ffpa_pkg::COUNT_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         cmd_i,
  input  logic [ffpa_pkg::IDX_W-1:0]   entry_index_i,
  input  logic [ADDR_BITS-1:0]         entry_start_i,
  input  logic [ADDR_BITS-1:0]         entry_end_i,
  input  logic                         entry_free_i,
  input  logic [ADDR_BITS-1:0]         alloc_size_i,
  input  logic                         below_4g_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         status_o,
  output logic [ADDR_BITS-1:0]         alloc_start_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PB = ffpa_pkg::PAGE_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e                       state_q;
  logic [ffpa_pkg::COUNT_W-1:0] entry_count_q;
  logic [ADDR_BITS-1:0]         size_q;
  logic                         low_q;
  logic [PW-1:0]                cnt_q;
  logic [PW-1:0]                ptr_q;
  logic                         pend_q;
  logic [AW-1:0]                ev_addr_q;
  logic                         out_valid_q;
  logic                         status_q;
  logic [ADDR_BITS-1:0]         start_q;
  logic                         res_status_q;
  logic [ADDR_BITS-1:0]         res_start_q;

  logic                 in_take;
  logic                 is_write;
  logic                 ent_we;
  logic [AW-1:0]        ent_waddr;
  logic                 size_ovf;
  logic [ADDR_BITS-1:0] size_round;
  logic [PW-1:0]        cnt_lim;
  logic                 rd_en;
  logic [ADDR_BITS-1:0] rd_start;
  logic [ADDR_BITS-1:0] rd_end;
  logic                 rd_free;
  ffpa_pkg::fit_t       fit;
  logic                 upd_we;
  logic [ADDR_BITS-1:0] upd_start;
  logic                 slot_free;
  logic                 fin;
  logic                 fin_status;
  logic [ADDR_BITS-1:0] fin_start;
  logic                 out_load;

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    in_take    = in_valid_i && in_ready_o;
    is_write   = (cmd_i == ffpa_pkg::CMD_WRITE);
    ent_we     = in_take && is_write && (int'(entry_index_i) < TABLE_DEPTH);
    ent_waddr  = AW'(entry_index_i);
    size_ovf   = (&alloc_size_i[ADDR_BITS-1:PB]) && (|alloc_size_i[PB-1:0]);
    size_round = {alloc_size_i[ADDR_BITS-1:PB] + (ADDR_BITS-PB)'(|alloc_size_i[PB-1:0]),
                  {PB{1'b0}}};
    cnt_lim    = (int'(entry_count_q) > TABLE_DEPTH) ? PW'(TABLE_DEPTH) : PW'(entry_count_q);
    rd_en      = (state_q == S_SCAN) && (ptr_q < cnt_q);
    upd_we     = (state_q == S_SCAN) && pend_q && fit.hit;
    upd_start  = rd_start + size_q;
    slot_free  = !out_valid_q || out_ready_i;
  end

  ffpa_table #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .ADDR_BITS  (ADDR_BITS)
  ) u_table (
    .clk_i       (clk_i),
    .ent_we_i    (ent_we),
    .ent_waddr_i (ent_waddr),
    .ent_wstart_i(entry_start_i),
    .ent_wend_i  (entry_end_i),
    .ent_wfree_i (entry_free_i),
    .upd_we_i    (upd_we),
    .upd_waddr_i (ev_addr_q),
    .upd_wstart_i(upd_start),
    .rd_en_i     (rd_en),
    .rd_addr_i   (ptr_q[AW-1:0]),
    .rd_start_o  (rd_start),
    .rd_end_o    (rd_end),
    .rd_free_o   (rd_free)
  );

  ffpa_fit #(
    .ADDR_BITS(ADDR_BITS)
  ) u_fit (
    .free_i    (rd_free),
    .lo_i      (rd_start),
    .hi_i      (rd_end),
    .size_i    (size_q),
    .low_only_i(low_q),
    .fit_o     (fit)
  );

  always_comb begin
    fin        = 1'b0;
    fin_status = ffpa_pkg::STATUS_NOMEM;
    fin_start  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (is_write) begin
            fin        = 1'b1;
            fin_status = ffpa_pkg::STATUS_OK;
          end else if (size_ovf || (cnt_lim == '0)) begin
            fin = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (pend_q && fit.hit) begin
          fin        = 1'b1;
          fin_status = ffpa_pkg::STATUS_OK;
          fin_start  = rd_start;
        end else if (pend_q && fit.stop) begin
          fin = 1'b1;
        end else if (!pend_q && (ptr_q == cnt_q)) begin
          fin = 1'b1;
        end
      end
      default: ;
    endcase
    out_load = slot_free && (fin || (state_q == S_DONE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      ptr_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_take && !fin) begin
            size_q  <= size_round;
            low_q   <= below_4g_i;
            cnt_q   <= cnt_lim;
            ptr_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          pend_q <= rd_en && !fin;
          if (rd_en) begin
            ptr_q     <= ptr_q + PW'(1);
            ev_addr_q <= ptr_q[AW-1:0];
          end
        end
        S_DONE: begin
          if (slot_free) begin
            status_q <= res_status_q;
            start_q  <= res_start_q;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (fin) begin
        if (slot_free) begin
          status_q <= fin_status;
          start_q  <= fin_start;
          state_q  <= S_IDLE;
        end else begin
          res_status_q <= fin_status;
          res_start_q  <= fin_start;
          state_q      <= S_DONE;
        end
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign alloc_start_o = start_q;

`ifndef SYNTHESIS
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN))
    else $error("read data pending outside scan");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (ptr_q <= cnt_q))
    else $error("scan pointer beyond entry count");

  a_upd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_we |-> (PW'(ev_addr_q) < cnt_q))
    else $error("table update outside scanned range");

  a_done_holds_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> out_valid_q)
    else $error("result held back while output is empty");

  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_take && is_write) |=> (state_q != S_SCAN))
    else $error("write transaction entered the scan");
`endif

endmodule
